FILE: rtl/software_timer_pool_defines.svh
// Assertion macros for the checker file of the timer pool.
`ifndef SOFTWARE_TIMER_POOL_DEFINES_SVH
`define SOFTWARE_TIMER_POOL_DEFINES_SVH

// Checked on every clock edge outside reset.
`define STP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define STP_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: rtl/stp_pkg.sv
`default_nettype none

package stp_pkg;

  localparam int SLOT_COUNT = 8;
  localparam int SLOT_IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_SET   = 2'd1;
  localparam logic [1:0] OP_KILL  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  localparam logic [1:0] STATUS_DONE      = 2'd0;
  localparam logic [1:0] STATUS_DROPPED   = 2'd1;
  localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

  typedef struct packed {
    logic [1:0]  operation;
    logic [4:0]  timer_id;
    logic [31:0] duration;
    logic [31:0] clear_mask;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] expired_now;
    logic [31:0] flags;
  } resp_t;

  typedef struct packed {
    logic load;
    logic walk;
    logic apply;
    logic emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic walk_last;
    logic resp_busy;
  } dp_status_t;

endpackage

`default_nettype wire

FILE: rtl/stp_ctrl.sv
`default_nettype none

module stp_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  stp_pkg::dp_status_t stat,
  output stp_pkg::ctrl_cmd_t  cmd
);
  import stp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_WALK  = 4'b0010,
    ST_APPLY = 4'b0100,
    ST_EMIT  = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (stat.walk_last) begin
          state_next = ST_APPLY;
        end
      end
      ST_APPLY: begin
        cmd.apply  = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (!stat.resp_busy) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/stp_datapath.sv
`default_nettype none

module stp_datapath (
  input  logic                clk,
  input  logic                rst,
  input  stp_pkg::ctrl_cmd_t  cmd,
  output stp_pkg::dp_status_t stat,
  input  stp_pkg::req_t       req,
  output logic                resp_valid,
  input  logic                resp_ready,
  output stp_pkg::resp_t      resp
);
  import stp_pkg::*;

  req_t                  item;
  logic [SLOT_IDX_W-1:0] idx;
  logic [SLOT_COUNT-1:0] slot_active;
  logic [4:0]            slot_timer_id  [SLOT_COUNT];
  logic [31:0]           slot_remaining [SLOT_COUNT];
  logic [31:0]           flags;
  logic [31:0]           expired;
  logic                  hit_found;
  logic [SLOT_IDX_W-1:0] hit_idx;
  logic                  free_found;
  logic [SLOT_IDX_W-1:0] free_idx;
  logic [1:0]            status;

  logic        cur_active;
  logic [4:0]  cur_id;
  logic [31:0] cur_rem;
  logic        is_tick;
  logic        is_set;
  logic        is_kill;
  logic        is_clear;
  logic        tick_expire;
  logic        tick_count;

  assign cur_active = slot_active[idx];
  assign cur_id     = slot_timer_id[idx];
  assign cur_rem    = slot_remaining[idx];

  assign is_tick  = (item.operation == OP_TICK);
  assign is_set   = (item.operation == OP_SET);
  assign is_kill  = (item.operation == OP_KILL);
  assign is_clear = (item.operation == OP_CLEAR);

  assign tick_expire = cmd.walk && is_tick && cur_active && (cur_rem == 32'd0);
  assign tick_count  = cmd.walk && is_tick && cur_active && (cur_rem != 32'd0);

  assign stat.walk_last = (idx == SLOT_IDX_W'(SLOT_COUNT - 1));
  assign stat.resp_busy = resp_valid && !resp_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      item       <= req;
      idx        <= '0;
      hit_found  <= 1'b0;
      free_found <= 1'b0;
      expired    <= '0;
    end else if (cmd.walk) begin
      idx <= idx + SLOT_IDX_W'(1);
      if (cur_active && (cur_id == item.timer_id) && !hit_found) begin
        hit_found <= 1'b1;
        hit_idx   <= idx;
      end
      if (!cur_active) begin
        free_found <= 1'b1;
        free_idx   <= idx;
      end
      if (tick_expire) begin
        expired <= expired | (32'd1 << cur_id);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_active <= '0;
    end else if (tick_expire) begin
      slot_active[idx] <= 1'b0;
    end else if (cmd.apply) begin
      if (is_set && !hit_found && free_found) begin
        slot_active[free_idx] <= 1'b1;
      end else if (is_kill && hit_found) begin
        slot_active[hit_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (tick_count) begin
      slot_remaining[idx] <= cur_rem - 32'd1;
    end else if (cmd.apply) begin
      if (is_set && hit_found) begin
        slot_remaining[hit_idx] <= item.duration;
      end else if (is_set && free_found) begin
        slot_timer_id[free_idx]  <= item.timer_id;
        slot_remaining[free_idx] <= item.duration;
      end else if (is_kill && hit_found) begin
        slot_remaining[hit_idx] <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags <= '0;
    end else if (cmd.apply) begin
      if (is_tick) begin
        flags <= flags | expired;
      end else if (is_clear) begin
        flags <= flags & ~item.clear_mask;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.apply) begin
      status <= STATUS_DONE;
      if (is_set && !hit_found && !free_found) begin
        status <= STATUS_DROPPED;
      end else if (is_kill && !hit_found) begin
        status <= STATUS_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      resp_valid <= 1'b0;
    end else if (cmd.emit) begin
      resp_valid <= 1'b1;
    end else if (resp_ready) begin
      resp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      resp.status      <= status;
      resp.expired_now <= expired;
      resp.flags       <= flags;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/software_timer_pool.sv
// Pool of one-shot timer slots driven by a request channel (req_valid, req_ready, req)
// and a response channel (resp_valid, resp_ready, resp), both valid/ready.
// Each request item is a tick, a set, a kill or a flag clear, and yields exactly
// one response item with a status, the ids that expired on a tick, and the
// sticky expiry flag word after the operation.
// Every item walks all slots, one slot per clock, then applies the update and
// loads the response register. A new item is taken only once the last one has
// loaded its response register.
// The response sits in an output register, so the next item is accepted while
// an earlier response still waits. If the receiver stalls longer than one item
// takes, the block holds the finished item in its last step and accepts nothing
// until the output register frees.
// A synchronous reset frees all slots, clears the flag word and drops any
// response that was pending.
`default_nettype none

module software_timer_pool (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_ready,
  input  stp_pkg::req_t  req,
  output logic           resp_valid,
  input  logic           resp_ready,
  output stp_pkg::resp_t resp
);
  import stp_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  stp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  stp_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

endmodule

`default_nettype wire

FILE: rtl/stp_checker.sv
`default_nettype none

`include "software_timer_pool_defines.svh"

module stp_checker (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           req_valid,
  input wire logic           req_ready,
  input wire logic           resp_valid,
  input wire logic           resp_ready,
  input wire stp_pkg::resp_t resp
);
  import stp_pkg::*;

  logic resp_stalled;
  logic status_known;
  logic expired_flagged;

  assign resp_stalled    = resp_valid && !resp_ready;
  assign status_known    = (resp.status == STATUS_DONE) || (resp.status == STATUS_DROPPED) ||
                           (resp.status == STATUS_NOT_FOUND);
  assign expired_flagged = (resp.expired_now & ~resp.flags) == 32'd0;

  `STP_ASSERT(a_resp_hold, resp_stalled |=> resp_valid && $stable(resp), "stalled item changed")
  `STP_ASSERT_ALWAYS(a_reset_empty, rst |=> !resp_valid, "response valid right after reset")
  `STP_ASSERT(a_status_code, resp_valid |-> status_known, "undefined status code")
  `STP_ASSERT(a_expired_flagged, resp_valid |-> expired_flagged, "expired id not flagged")
  `STP_ASSERT(a_busy_after_accept, req_valid && req_ready |=> !req_ready, "item taken while busy")

endmodule

bind software_timer_pool stp_checker u_stp_checker (.*);

`default_nettype wire

FILE: tb/tb_software_timer_pool.sv
`default_nettype none

module tb_software_timer_pool;
  import stp_pkg::*;

  logic  clk;
  logic  rst;
  logic  req_valid;
  logic  req_ready;
  req_t  req;
  logic  resp_valid;
  logic  resp_ready;
  resp_t resp;

  software_timer_pool u_top (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .req        (req),
    .resp_valid (resp_valid),
    .resp_ready (resp_ready),
    .resp       (resp)
  );

  // Shadow copy of the timer slots and the sticky flag word.
  logic        pool_busy   [SLOT_COUNT];
  logic [4:0]  pool_id     [SLOT_COUNT];
  logic [31:0] pool_ticks  [SLOT_COUNT];
  logic [31:0] pool_flags;

  resp_t awaited_resp [$];
  req_t  row_req      [$];
  bit    row_typed    [$];
  resp_t row_resp     [$];

  int    mismatches;
  int    resp_seen;
  bit    no_gaps;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 400000);
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic resp_t advance_pool(req_t r);
    resp_t o;
    int    hit;
    int    free_idx;
    o        = '0;
    hit      = -1;
    free_idx = -1;
    case (r.operation)
      OP_TICK: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (pool_busy[i]) begin
            if (pool_ticks[i] != 32'd0) begin
              pool_ticks[i] = pool_ticks[i] - 32'd1;
            end else begin
              o.expired_now[pool_id[i]] = 1'b1;
              pool_busy[i] = 1'b0;
            end
          end
        end
        pool_flags = pool_flags | o.expired_now;
      end
      OP_SET, OP_KILL: begin
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
          if (pool_busy[i] && pool_id[i] == r.timer_id) hit = i;
          if (!pool_busy[i] && free_idx < 0) free_idx = i;
        end
        if (r.operation == OP_SET) begin
          if (hit >= 0) begin
            pool_ticks[hit] = r.duration;
          end else if (free_idx >= 0) begin
            pool_busy[free_idx]  = 1'b1;
            pool_id[free_idx]    = r.timer_id;
            pool_ticks[free_idx] = r.duration;
          end else begin
            o.status = STATUS_DROPPED;
          end
        end else if (hit >= 0) begin
          pool_busy[hit]  = 1'b0;
          pool_ticks[hit] = 32'd0;
        end else begin
          o.status = STATUS_NOT_FOUND;
        end
      end
      default: pool_flags = pool_flags & ~r.clear_mask;
    endcase
    o.flags = pool_flags;
    return o;
  endfunction

  function automatic int pick_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic add_row(logic [1:0] op, logic [4:0] id, logic [31:0] dur,
                         logic [31:0] mask, bit typed, resp_t exp);
    req_t r;
    r.operation  = op;
    r.timer_id   = id;
    r.duration   = dur;
    r.clear_mask = mask;
    row_req.push_back(r);
    row_typed.push_back(typed);
    row_resp.push_back(exp);
  endtask

  task automatic send_item(req_t r, bit typed, resp_t typed_exp);
    resp_t pred;
    int    gap;
    @(negedge clk);
    req       <= r;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    pred = advance_pool(r);
    awaited_resp.push_back(typed ? typed_exp : pred);
    gap = pick_gap(no_gaps);
    if (gap > 0) begin
      @(negedge clk);
      req_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Receiver: random stalls, quiet stretches, and one long hold-off that
  // lets the pool back up into its input.
  initial begin
    int  hold;
    int  quiet;
    bit  long_hold_done;
    hold           = 0;
    quiet          = 0;
    long_hold_done = 1'b0;
    forever begin
      @(negedge clk);
      if (!long_hold_done && resp_seen >= 300) begin
        long_hold_done = 1'b1;
        hold           = 400;
      end
      if (hold > 0) begin
        resp_ready <= 1'b0;
        hold--;
      end else begin
        resp_ready <= 1'b1;
        if (quiet > 0) begin
          quiet--;
        end else if ($urandom_range(0, 99) < 4) begin
          quiet = $urandom_range(30, 80);
        end else begin
          hold = pick_gap(1'b0);
        end
      end
    end
  end

  always @(posedge clk) begin : check_resp
    resp_t exp;
    if (!rst && resp_valid && resp_ready) begin
      resp_seen++;
      if (awaited_resp.size() == 0) begin
        $display("%0t: unexpected item, expected none, actual %h", $time, resp);
        mismatches++;
      end else begin
        exp = awaited_resp.pop_front();
        if (resp.status !== exp.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp.status, resp.status);
          mismatches++;
        end
        if (resp.expired_now !== exp.expired_now) begin
          $display("%0t: expired_now expected %h actual %h",
                   $time, exp.expired_now, resp.expired_now);
          mismatches++;
        end
        if (resp.flags !== exp.flags) begin
          $display("%0t: flags expected %h actual %h", $time, exp.flags, resp.flags);
          mismatches++;
        end
      end
    end
  end

  initial begin
    req_t  r;
    resp_t none;
    int    k;
    int    pick;
    rst           = 1'b1;
    req_valid     = 1'b0;
    req           = '0;
    resp_ready    = 1'b0;
    mismatches    = 0;
    resp_seen     = 0;
    no_gaps       = 1'b0;
    none          = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      pool_busy[i]  = 1'b0;
      pool_id[i]    = 5'd0;
      pool_ticks[i] = 32'd0;
    end
    pool_flags = 32'd0;

    add_row(OP_TICK,  5'd0,  32'd0, 32'd0, 1'b1, resp_t'{STATUS_DONE, 32'd0, 32'd0});
    add_row(OP_KILL,  5'd5,  32'd0, 32'd0, 1'b1, resp_t'{STATUS_NOT_FOUND, 32'd0, 32'd0});
    add_row(OP_CLEAR, 5'd0,  32'd0, 32'hFFFF_FFFF, 1'b1,
            resp_t'{STATUS_DONE, 32'd0, 32'd0});
    add_row(OP_SET,   5'd0,  32'd0, 32'd0, 1'b0, none);
    add_row(OP_SET,   5'd31, 32'hFFFF_FFFF, 32'd0, 1'b0, none);
    add_row(OP_TICK,  5'd0,  32'd0, 32'd0, 1'b0, none);
    add_row(OP_SET,   5'd31, 32'd1, 32'd0, 1'b0, none);
    for (k = 1; k < 8; k++) add_row(OP_SET, k[4:0], 32'd2, 32'd0, 1'b0, none);
    add_row(OP_SET,   5'd8,  32'd3, 32'd0, 1'b1,
            resp_t'{STATUS_DROPPED, 32'd0, 32'h0000_0001});
    add_row(OP_KILL,  5'd31, 32'd0, 32'd0, 1'b0, none);
    add_row(OP_KILL,  5'd31, 32'd0, 32'd0, 1'b1,
            resp_t'{STATUS_NOT_FOUND, 32'd0, 32'h0000_0001});
    add_row(OP_TICK,  5'd0,  32'd0, 32'd0, 1'b0, none);
    add_row(OP_TICK,  5'd0,  32'd0, 32'd0, 1'b0, none);
    add_row(OP_TICK,  5'd0,  32'd0, 32'd0, 1'b0, none);
    add_row(OP_CLEAR, 5'd0,  32'd0, 32'h0000_0002, 1'b0, none);
    add_row(OP_CLEAR, 5'd0,  32'd0, 32'd0, 1'b0, none);
    add_row(OP_CLEAR, 5'd0,  32'd0, 32'hFFFF_FFFF, 1'b1,
            resp_t'{STATUS_DONE, 32'd0, 32'd0});
    add_row(OP_SET,   5'd12, 32'd0, 32'd0, 1'b0, none);
    add_row(OP_TICK,  5'd0,  32'd0, 32'd0, 1'b0, none);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (row_req[i]) send_item(row_req[i], row_typed[i], row_resp[i]);

    for (k = 0; k < 650; k++) begin
      no_gaps = ((k / 40) % 5) == 2;
      r.operation  = OP_TICK;
      r.timer_id   = $urandom_range(0, 31);
      r.duration   = $urandom;
      r.clear_mask = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 70) r.timer_id = $urandom_range(0, 11);
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        r.operation = OP_TICK;
      end else if (pick < 70) begin
        r.operation = OP_SET;
        pick = $urandom_range(0, 99);
        if (pick < 70) r.duration = $urandom_range(0, 6);
        else if (pick < 90) r.duration = $urandom_range(0, 40);
      end else if (pick < 88) begin
        r.operation = OP_KILL;
      end else begin
        r.operation = OP_CLEAR;
        if ($urandom_range(0, 1) == 0) r.clear_mask = 32'd1 << $urandom_range(0, 31);
      end
      send_item(r, 1'b0, none);
    end
    @(negedge clk);
    req_valid <= 1'b0;

    while (awaited_resp.size() != 0) @(posedge clk);
    repeat (3 * SLOT_COUNT + 8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire

FILE: filelist.f
+incdir+rtl
rtl/stp_pkg.sv
rtl/stp_ctrl.sv
rtl/stp_datapath.sv
rtl/software_timer_pool.sv
rtl/stp_checker.sv
tb/tb_software_timer_pool.sv
